// File: sv/assert_macros.svh
// Assertion macros used by the sequencer RTL (ttlc_fsm) of the cache table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked property, switched off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/ttlc_pkg.sv
// Shared types, constants and helpers for the expiring name cache table.
package ttlc_pkg;

  localparam int ENTRIES  = 64;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W   = 32;
  localparam int TIME_W   = 32;
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int CLR_W    = 7;
  localparam int WORD_W   = KEY_BITS + ADDR_W + TIME_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
  localparam logic [CLR_W-1:0] CLR_MAX  = {CLR_W{1'b1}};

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_SWEEP  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // One request as captured at acceptance.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_BITS-1:0] key;
    logic [ADDR_W-1:0]   addr;
    logic [TIME_W-1:0]   ttl;
    logic [TIME_W-1:0]   now;
  } req_t;

  // Scan control from the sequencer to the entry evaluator.
  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             eval;
    logic [IDX_W-1:0] eval_idx;
    logic             finish;
  } ctl_t;

  // One result item.
  typedef struct packed {
    logic              found;
    logic              fresh;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
    logic [CLR_W-1:0]  cleared;
  } res_t;

  // Low SLOT_W bits of a slot index, zero extended for small tables.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// File: sv/ttlc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module ttlc_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 128,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/ttlc_fsm.sv
// Sequencer that walks the table one entry per cycle for each item.
`include "assert_macros.svh"

module ttlc_fsm (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output ttlc_pkg::ctl_t ctl
);

  ttlc_pkg::state_t            state;
  ttlc_pkg::state_t            state_next;
  logic [ttlc_pkg::IDX_W-1:0]  cnt;
  logic                        eval_q;
  logic [ttlc_pkg::IDX_W-1:0]  eval_idx;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttlc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ttlc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ttlc_pkg::ST_SCAN;
        end
      end
      ttlc_pkg::ST_SCAN: begin
        if (cnt == ttlc_pkg::IDX_LAST) begin
          state_next = ttlc_pkg::ST_DRAIN;
        end
      end
      ttlc_pkg::ST_DRAIN: state_next = ttlc_pkg::ST_FIN;
      ttlc_pkg::ST_FIN:   state_next = ttlc_pkg::ST_IDLE;
      default:            state_next = ttlc_pkg::ST_IDLE;
    endcase
  end

  // Read index counter; it restarts at zero whenever the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ttlc_pkg::ST_SCAN) begin
      cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
  end

  // Read data arrives in the cycle after the read, so the evaluate strobe and index are registered to trail it.
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_q <= 1'b0;
    end else begin
      eval_q <= (state == ttlc_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    eval_idx <= cnt;
  end

  // Outputs.
  always_comb begin
    busy         = (state != ttlc_pkg::ST_IDLE);
    ctl.load     = (state == ttlc_pkg::ST_IDLE) && start;
    ctl.rd_en    = (state == ttlc_pkg::ST_SCAN);
    ctl.rd_idx   = cnt;
    ctl.eval     = eval_q;
    ctl.eval_idx = eval_idx;
    ctl.finish   = (state == ttlc_pkg::ST_FIN);
  end

  `ASSERT_RST(a_phases_exclusive, clk, rst, $onehot0({ctl.load, ctl.rd_en, ctl.finish}), "load, read and finish overlap")
  `ASSERT_RST(a_finish_after_last, clk, rst, ctl.finish |-> ($past(eval_q) && ($past(eval_idx) == ttlc_pkg::IDX_LAST)), "finish without evaluating the last entry")
  `ASSERT_RST(a_load_then_busy, clk, rst, ctl.load |=> (busy && ctl.rd_en && (ctl.rd_idx == '0)), "scan did not start at entry zero")
  `ASSERT_RST(a_finish_then_idle, clk, rst, ctl.finish |=> !busy, "block stayed busy after finishing")

endmodule

// File: sv/ttlc_eval.sv
// Per-entry evaluation: valid bits, lookup match, insert slot choice, sweep.
module ttlc_eval (
  input  logic                         clk,
  input  logic                         rst,
  input  ttlc_pkg::ctl_t               ctl,
  input  ttlc_pkg::req_t               req_in,
  input  logic [ttlc_pkg::WORD_W-1:0]  rd_data,
  output logic                         wr_en,
  output logic [ttlc_pkg::IDX_W-1:0]   wr_idx,
  output logic [ttlc_pkg::WORD_W-1:0]  wr_data,
  output ttlc_pkg::res_t               res
);

  ttlc_pkg::req_t                      req;
  logic [ttlc_pkg::ENTRIES-1:0]        valid;

  logic                                hit;
  logic                                hit_fresh;
  logic [ttlc_pkg::ADDR_W-1:0]         hit_addr;
  logic [ttlc_pkg::IDX_W-1:0]          hit_idx;
  logic                                have_free;
  logic [ttlc_pkg::IDX_W-1:0]          free_idx;
  logic [ttlc_pkg::IDX_W-1:0]          victim;
  logic [ttlc_pkg::TIME_W-1:0]         oldest;
  logic [ttlc_pkg::CLR_W-1:0]          cleared;

  logic [ttlc_pkg::KEY_BITS-1:0]       ent_key;
  logic [ttlc_pkg::ADDR_W-1:0]         ent_addr;
  logic [ttlc_pkg::TIME_W-1:0]         ent_exp;
  logic                                ent_valid;
  logic                                expired;
  logic [ttlc_pkg::TIME_W:0]           exp_sum;
  logic [ttlc_pkg::TIME_W-1:0]         new_exp;
  logic [ttlc_pkg::IDX_W-1:0]          ins_idx;

  // Split the entry that the memory returned.
  always_comb begin
    ent_key   = rd_data[ttlc_pkg::WORD_W-1 -: ttlc_pkg::KEY_BITS];
    ent_addr  = rd_data[ttlc_pkg::ADDR_W+ttlc_pkg::TIME_W-1 -: ttlc_pkg::ADDR_W];
    ent_exp   = rd_data[ttlc_pkg::TIME_W-1:0];
    ent_valid = valid[ctl.eval_idx];
    expired   = ent_valid && (ent_exp < req.now);
  end

  // Capture the request when it is accepted.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req <= req_in;
    end
  end

  // Scan accumulators for all three operations.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit       <= 1'b0;
      have_free <= 1'b0;
      cleared   <= '0;
    end else if (ctl.load) begin
      hit       <= 1'b0;
      have_free <= 1'b0;
      cleared   <= '0;
      free_idx  <= '0;
      victim    <= '0;
      hit_idx   <= '0;
      hit_fresh <= 1'b0;
      hit_addr  <= '0;
      oldest    <= req_in.now;
    end else if (ctl.eval) begin
      case (req.op)
        ttlc_pkg::OP_LOOKUP: begin
          if (!hit && ent_valid && (ent_key == req.key)) begin
            hit       <= 1'b1;
            hit_fresh <= (req.now < ent_exp);
            hit_addr  <= ent_addr;
            hit_idx   <= ctl.eval_idx;
          end
        end
        ttlc_pkg::OP_INSERT: begin
          // The first free slot wins; before it, track the oldest stale entry.
          if (!have_free) begin
            if (!ent_valid) begin
              have_free <= 1'b1;
              free_idx  <= ctl.eval_idx;
            end else if (ent_exp < oldest) begin
              oldest <= ent_exp;
              victim <= ctl.eval_idx;
            end
          end
        end
        ttlc_pkg::OP_SWEEP: begin
          if (expired && (cleared != ttlc_pkg::CLR_MAX)) begin
            cleared <= cleared + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Insert target and saturated expiry.
  always_comb begin
    ins_idx = have_free ? free_idx : victim;
    exp_sum = {1'b0, req.now} + {1'b0, req.ttl};
    new_exp = exp_sum[ttlc_pkg::TIME_W] ? {ttlc_pkg::TIME_W{1'b1}}
                                        : exp_sum[ttlc_pkg::TIME_W-1:0];
    wr_en   = ctl.finish && (req.op == ttlc_pkg::OP_INSERT);
    wr_idx  = ins_idx;
    wr_data = {req.key, req.addr, new_exp};
  end

  // Valid bits: sweep clears during the scan, insert sets at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.eval && (req.op == ttlc_pkg::OP_SWEEP) && expired) begin
        valid[ctl.eval_idx] <= 1'b0;
      end
      if (wr_en) begin
        valid[ins_idx] <= 1'b1;
      end
    end
  end

  // Result fields; fields an operation does not use stay zero.
  always_comb begin
    res = '0;
    case (req.op)
      ttlc_pkg::OP_LOOKUP: begin
        res.found = hit;
        res.fresh = hit && hit_fresh;
        res.addr  = hit ? hit_addr : '0;
        res.slot  = hit ? ttlc_pkg::to_slot(hit_idx) : '0;
      end
      ttlc_pkg::OP_INSERT: res.slot    = ttlc_pkg::to_slot(ins_idx);
      ttlc_pkg::OP_SWEEP:  res.cleared = cleared;
      default:             res = '0;
    endcase
  end

endmodule

// File: sv/ttl_cache_table_top.sv
// Top level of the expiring name cache table.
//
// Command channel: an item is accepted at a rising edge where start is high
// and busy is low. The item carries operation (lookup, insert or sweep), a
// name key, an address, a lifetime and the current time in seconds.
// Result channel: done is high for exactly one cycle and the result ports
// hold found, fresh, address_out, slot_used and cleared_count in that cycle.
// The receiver cannot stall; each item gives exactly one result.
// Sequence: every item walks all ENTRIES slots through the entry memory, one
// read a cycle, then passes a drain and a finish state, with busy high
// throughout; done rises in the same cycle that busy falls. A new item can
// be taken in that same cycle; no item is taken while the last one is busy.
// The single read port of the entry memory sets the pace of the scan.
// Reset: the valid bit of every slot is cleared at once, so the table is
// empty from the first cycle after reset; no clearing pass is needed.
module ttl_cache_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ttlc_pkg::OP_W-1:0]     operation,
  input  logic [63:0]                   name_key,
  input  logic [ttlc_pkg::ADDR_W-1:0]   address_in,
  input  logic [ttlc_pkg::TIME_W-1:0]   ttl_seconds,
  input  logic [ttlc_pkg::TIME_W-1:0]   now_seconds,
  output logic                          done,
  output logic                          found,
  output logic                          fresh,
  output logic [ttlc_pkg::ADDR_W-1:0]   address_out,
  output logic [ttlc_pkg::SLOT_W-1:0]   slot_used,
  output logic [ttlc_pkg::CLR_W-1:0]    cleared_count
);

  ttlc_pkg::ctl_t                      ctl;
  ttlc_pkg::req_t                      req_in;
  ttlc_pkg::res_t                      res;
  logic                                wr_en;
  logic [ttlc_pkg::IDX_W-1:0]          wr_idx;
  logic [ttlc_pkg::WORD_W-1:0]         wr_data;
  logic [ttlc_pkg::WORD_W-1:0]         rd_data;

  // Gather the command ports; only the low KEY_BITS of the key are kept.
  always_comb begin
    req_in.op   = operation;
    req_in.key  = name_key[ttlc_pkg::KEY_BITS-1:0];
    req_in.addr = address_in;
    req_in.ttl  = ttl_seconds;
    req_in.now  = now_seconds;
  end

  ttlc_fsm u_fsm (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  ttlc_ram #(
    .DEPTH  (ttlc_pkg::ENTRIES),
    .WIDTH  (ttlc_pkg::WORD_W),
    .ADDR_W (ttlc_pkg::IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_idx),
    .rd_data (rd_data)
  );

  ttlc_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .req_in  (req_in),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .res     (res)
  );

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  // Result register, loaded as the item finishes.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      found         <= res.found;
      fresh         <= res.fresh;
      address_out   <= res.addr;
      slot_used     <= res.slot;
      cleared_count <= res.cleared;
    end
  end

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the expiring name cache table.
`timescale 1ns / 1ps

module tb_top;
  import ttlc_pkg::*;

  // Operation code that must leave the table unchanged and give an all-zero result.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE    = 16;
  localparam int DRAIN_CYCLES = ENTRIES + 8;
  localparam int MAX_REPORTS  = 10;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              start         = 1'b0;
  logic [OP_W-1:0]   operation     = '0;
  logic [63:0]       name_key      = '0;
  logic [ADDR_W-1:0] address_in    = '0;
  logic [TIME_W-1:0] ttl_seconds   = '0;
  logic [TIME_W-1:0] now_seconds   = '0;
  logic              busy;
  logic              done;
  logic              found;
  logic              fresh;
  logic [ADDR_W-1:0] address_out;
  logic [SLOT_W-1:0] slot_used;
  logic [CLR_W-1:0]  cleared_count;

  ttl_cache_table_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .name_key      (name_key),
    .address_in    (address_in),
    .ttl_seconds   (ttl_seconds),
    .now_seconds   (now_seconds),
    .done          (done),
    .found         (found),
    .fresh         (fresh),
    .address_out   (address_out),
    .slot_used     (slot_used),
    .cleared_count (cleared_count)
  );

  always #1 clk = ~clk;

  // Shadow copy of the cache table.
  logic                shadow_valid  [ENTRIES];
  logic [KEY_BITS-1:0] shadow_key    [ENTRIES];
  logic [ADDR_W-1:0]   shadow_addr   [ENTRIES];
  logic [TIME_W-1:0]   shadow_expiry [ENTRIES];

  res_t        expected_results[$];
  logic [63:0] key_pool [POOL_SIZE];
  int          sender_idle_pct = 0;
  int          mismatch_count  = 0;
  int          result_count    = 0;
  int          lookups_sent    = 0;
  int          lookup_hits     = 0;
  int          inserts_sent    = 0;
  int          full_inserts    = 0;
  int          sweeps_sent     = 0;
  int          unused_sent     = 0;

  // Applies one request to the shadow table and returns the result it gives.
  function automatic res_t apply_request(input req_t r);
    res_t                outcome;
    logic [KEY_BITS-1:0] k;
    logic [TIME_W-1:0]   oldest;
    logic [TIME_W:0]     sum;
    int                  target;
    int                  victim;
    int                  cleared;
    bit                  have_free;
    bit                  hit;
    outcome = '0;
    k = r.key[KEY_BITS-1:0];
    case (r.op)
      OP_LOOKUP: begin
        lookups_sent++;
        hit = 1'b0;
        // The first valid slot with an equal key wins.
        for (int i = 0; i < ENTRIES; i++) begin
          if (!hit && shadow_valid[i] && shadow_key[i] == k) begin
            hit = 1'b1;
            outcome.found = 1'b1;
            outcome.fresh = (r.now < shadow_expiry[i]);
            outcome.addr  = shadow_addr[i];
            outcome.slot  = SLOT_W'(i);
          end
        end
        if (hit) lookup_hits++;
      end
      OP_INSERT: begin
        inserts_sent++;
        target    = 0;
        victim    = 0;
        oldest    = r.now;
        have_free = 1'b0;
        // Take the first free slot; on the way, track the oldest expired entry.
        for (int i = 0; i < ENTRIES; i++) begin
          if (!have_free) begin
            if (!shadow_valid[i]) begin
              target    = i;
              have_free = 1'b1;
            end else if (shadow_expiry[i] < oldest) begin
              oldest = shadow_expiry[i];
              victim = i;
            end
          end
        end
        if (!have_free) begin
          target = victim;
          full_inserts++;
        end
        sum = {1'b0, r.now} + {1'b0, r.ttl};
        shadow_valid[target]  = 1'b1;
        shadow_key[target]    = k;
        shadow_addr[target]   = r.addr;
        shadow_expiry[target] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        outcome.slot = SLOT_W'(target);
      end
      OP_SWEEP: begin
        sweeps_sent++;
        cleared = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i] && shadow_expiry[i] < r.now) begin
            shadow_valid[i]  = 1'b0;
            shadow_key[i]    = '0;
            shadow_addr[i]   = '0;
            shadow_expiry[i] = '0;
            cleared++;
          end
        end
        outcome.cleared = (cleared > int'(CLR_MAX)) ? CLR_MAX : CLR_W'(cleared);
      end
      default: unused_sent++;
    endcase
    return outcome;
  endfunction

  // Drives one item, waits until the block takes it, then idles at random.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [63:0] key,
                           input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] ttl,
                           input logic [TIME_W-1:0] now);
    req_t r;
    r.op   = op;
    r.key  = key[KEY_BITS-1:0];
    r.addr = addr;
    r.ttl  = ttl;
    r.now  = now;
    start       <= 1'b1;
    operation   <= op;
    name_key    <= key;
    address_in  <= addr;
    ttl_seconds <= ttl;
    now_seconds <= now;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_request(r));
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_all_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Field extremes, time boundaries, duplicates, the unused code and sweeps.
  task automatic test_directed_corners();
    sender_idle_pct = 37;
    send_item(OP_LOOKUP, '1, '1, '1, '1);
    send_item(OP_SWEEP, '1, '1, '1, '1);
    send_item(OP_INSERT, '0, '0, '0, '0);
    send_item(OP_INSERT, '1, '1, '1, '1);
    // The sum of time and lifetime runs past the top and saturates.
    send_item(OP_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 32'h1234_5678, 32'h0002_0000,
              32'hFFFF_0000);
    send_item(OP_INSERT, key_pool[0], $urandom, 32'd10, 32'd100);
    send_item(OP_LOOKUP, '0, '0, '0, '0);
    send_item(OP_LOOKUP, '1, '0, '0, '1);
    send_item(OP_LOOKUP, '1, '0, '0, 32'd5);
    send_item(OP_LOOKUP, key_pool[0], '0, '0, 32'd109);
    send_item(OP_LOOKUP, key_pool[0], '0, '0, 32'd110);
    // A duplicate key is stored again; lookup still returns the first copy.
    send_item(OP_INSERT, '0, 32'hDEAD_BEEF, 32'd50, 32'd0);
    send_item(OP_LOOKUP, '0, '0, '0, 32'd0);
    send_item(OP_UNUSED, '1, '1, '1, '1);
    send_item(OP_UNUSED, '0, '0, '0, '0);
    send_item(OP_LOOKUP, '0, '0, '0, 32'd0);
    // Nothing is below time zero, then only the zero expiry goes.
    send_item(OP_SWEEP, '0, '0, '0, 32'd0);
    send_item(OP_SWEEP, '0, '0, '0, 32'd1);
    send_item(OP_LOOKUP, '0, '0, '0, 32'd1);
    send_item(OP_INSERT, key_pool[1], $urandom, 32'd1000, 32'd2);
    send_item(OP_SWEEP, '0, '0, '0, 32'd111);
    send_item(OP_LOOKUP, {$urandom, $urandom}, '0, '0, 32'd111);
  endtask

  // Fills the table, then exercises replacement of expired and of slot zero.
  task automatic test_full_table_replacement();
    logic [TIME_W-1:0] t;
    sender_idle_pct = 37;
    t = 32'd5000;
    for (int n = 0; n < 70; n++) begin
      send_item(OP_INSERT, key_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom,
                $urandom_range(0, 60), t);
      t = t + 1;
    end
    // Nothing has expired at time zero, so slot zero is overwritten.
    send_item(OP_INSERT, key_pool[2], $urandom, 32'd5, 32'd0);
    send_item(OP_LOOKUP, key_pool[2], '0, '0, 32'd0);
    wait_all_results();
    for (int n = 0; n < 10; n++)
      send_item(OP_LOOKUP, key_pool[n], '0, '0, t);
    for (int n = 0; n < 6; n++)
      send_item(OP_INSERT, {$urandom, $urandom}, $urandom, 32'd100, t + 40 + n);
    send_item(OP_SWEEP, '0, '0, '0, t + 80);
    for (int n = 0; n < 4; n++)
      send_item(OP_LOOKUP, key_pool[n + 10], '0, '0, t + 80);
  endtask

  // Random operations on a slowly advancing clock with mostly pooled keys.
  task automatic test_random_mix(input int idle_pct, input int count,
                                 input logic [TIME_W-1:0] base_time);
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] ttl;
    logic [63:0]       key;
    logic [OP_W-1:0]   op;
    int                pick;
    sender_idle_pct = idle_pct;
    clock_now = base_time;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 45) ? OP_LOOKUP : (pick < 85) ? OP_INSERT :
           (pick < 95) ? OP_SWEEP : OP_UNUSED;
      key = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      ttl = (pick < 7) ? $urandom_range(0, 400) :
            (pick < 9) ? $urandom_range(0, 100000) : $urandom;
      clock_now = clock_now + $urandom_range(0, 4);
      now = ($urandom_range(0, 9) == 0) ? $urandom : clock_now;
      send_item(op, key, $urandom, ttl, now);
    end
  endtask

  // Compare every result with the oldest outstanding expectation.
  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (!rst && done) begin
      seen.found   = found;
      seen.fresh   = fresh;
      seen.addr    = address_out;
      seen.slot    = slot_used;
      seen.cleared = cleared_count;
      result_count++;
      if (expected_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("Unexpected result %0d with no item outstanding: found=%0b fresh=%0b addr=%h slot=%0d cleared=%0d",
                   result_count, seen.found, seen.fresh, seen.addr, seen.slot, seen.cleared);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("Result %0d differs: expected found=%0b fresh=%0b addr=%h slot=%0d cleared=%0d",
                     result_count, want.found, want.fresh, want.addr, want.slot, want.cleared);
            $display("              got      found=%0b fresh=%0b addr=%h slot=%0d cleared=%0d",
                     seen.found, seen.fresh, seen.addr, seen.slot, seen.cleared);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i]  = 1'b0;
      shadow_key[i]    = '0;
      shadow_addr[i]   = '0;
      shadow_expiry[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_full_table_replacement();
    test_random_mix(37, 200, 32'd100);
    test_random_mix(81, 200, 32'hFFFF_F000);
    test_random_mix(0, 200, 32'd50000);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d lookups (%0d hits), %0d inserts (%0d into a full table),",
             lookups_sent, lookup_hits, inserts_sent, full_inserts);
    $display("%0d sweeps and %0d unused codes; %0d results compared.",
             sweeps_sent, unused_sent, result_count);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
